@@ hw/rtl/tagged_decimal_frame_parser_core_defines.svh @@
// assertion macros for the tagged decimal frame parser
`ifndef TAGGED_DECIMAL_FRAME_PARSER_CORE_DEFINES_SVH
`define TAGGED_DECIMAL_FRAME_PARSER_CORE_DEFINES_SVH

// checked only while out of reset
`define TDFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define TDFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/tdfp_pkg.sv @@
// shared constants and types of the tagged decimal frame parser
`default_nettype none

package tdfp_pkg;

    localparam int NUM_SLOTS_DEF   = 10;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TAG_IDX_W       = 5;

    localparam logic [7:0] CH_FIRST_TAG = 8'h61;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [2:0] {
        K_NONE,
        K_SPACE,
        K_TAG,
        K_MINUS,
        K_DIGIT,
        K_EOL
    } t_char_kind;

    typedef struct packed {
        t_char_kind           kind;
        logic [TAG_IDX_W-1:0] tag_idx;
        logic [3:0]           digit;
    } t_char_info;

endpackage

`default_nettype wire

@@ hw/rtl/tdfp_char_decode.sv @@
// classifies one received byte into tag, minus, digit, end of line, space or ignored
`default_nettype none

module tdfp_char_decode
    import tdfp_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic [7:0] i_byte,
    output t_char_info      o_info
);

    localparam logic [7:0] LAST_TAG = CH_FIRST_TAG + 8'(NUM_SLOTS - 1);

    logic [7:0] tag_off;
    logic [7:0] dig_off;

    assign tag_off = i_byte - CH_FIRST_TAG;
    assign dig_off = i_byte - CH_ZERO;

    always_comb begin
        o_info.tag_idx = tag_off[TAG_IDX_W-1:0];
        o_info.digit   = dig_off[3:0];
        if (i_byte >= CH_FIRST_TAG && i_byte <= LAST_TAG) begin
            o_info.kind = K_TAG;
        end else if (i_byte == CH_MINUS) begin
            o_info.kind = K_MINUS;
        end else if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
            o_info.kind = K_DIGIT;
        end else if (i_byte == CH_CR || i_byte == CH_LF) begin
            o_info.kind = K_EOL;
        end else if (i_byte == CH_SPACE) begin
            o_info.kind = K_SPACE;
        end else begin
            o_info.kind = K_NONE;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tdfp_digit_acc.sv @@
// value*10 plus signed digit, clamped to the signed value range
`default_nettype none

module tdfp_digit_acc
    import tdfp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [3:0]             i_digit,
    input  wire logic                   i_neg,
    output logic      [VALUE_WIDTH-1:0] o_value
);

    localparam int EW = VALUE_WIDTH + 5;
    localparam logic signed [EW-1:0] VMAX = {{(EW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [EW-1:0] VMIN = {{(EW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

    logic signed [EW-1:0] ext;
    logic signed [EW-1:0] prod;
    logic signed [EW-1:0] dext;
    logic signed [EW-1:0] sdig;
    logic signed [EW-1:0] sum;

    assign ext  = {{(EW-VALUE_WIDTH){i_value[VALUE_WIDTH-1]}}, i_value};
    assign prod = (ext <<< 3) + (ext <<< 1);
    assign dext = {{(EW-4){1'b0}}, i_digit};
    assign sdig = i_neg ? -dext : dext;
    assign sum  = prod + sdig;

    always_comb begin
        if (sum > VMAX) begin
            o_value = VMAX[VALUE_WIDTH-1:0];
        end else if (sum < VMIN) begin
            o_value = VMIN[VALUE_WIDTH-1:0];
        end else begin
            o_value = sum[VALUE_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tagged_decimal_frame_parser_core.sv @@
// a byte is registered in the input register on transfer and acted on from there;
// a CR or LF moves the slots into the output register that drives the master side
// throughput: one byte per cycle; a CR or LF waits in the input register
// only while the previous frame sits untaken in the output register
// reset (synchronous, active low) clears all slots, slot index and sign
`default_nettype none

module tagged_decimal_frame_parser_core
    import tdfp_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int O_DATA_W   = ((NUM_SLOTS * VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // rx_byte
    input  wire logic [7:0]          s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, gyro_x, gyro_y, gyro_z, grav_x, grav_y, grav_z
    output logic      [O_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic [VALUE_WIDTH-1:0] r_slot [NUM_SLOTS];
    logic [IDX_W-1:0]       r_idx;
    logic                   r_neg;
    logic                   r_out_valid;
    logic [O_DATA_W-1:0]    r_out_data;

    t_char_info             info;
    logic [VALUE_WIDTH-1:0] acc_value;
    logic [O_DATA_W-1:0]    n_frame;
    logic                   is_eol;
    logic                   out_free;
    logic                   proceed;

    tdfp_char_decode #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_decode (
        .i_byte (r_in_byte),
        .o_info (info)
    );

    tdfp_digit_acc #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_acc (
        .i_value (r_slot[r_idx]),
        .i_digit (info.digit),
        .i_neg   (r_neg),
        .o_value (acc_value)
    );

    assign is_eol        = (info.kind == K_EOL);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign proceed       = r_in_valid && (!is_eol || out_free);
    assign s_axis_tready = !r_in_valid || proceed;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_frame = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            n_frame[k*VALUE_WIDTH +: VALUE_WIDTH] = r_slot[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_slot[k] <= '0;
            end
            r_idx <= '0;
            r_neg <= 1'b0;
        end else if (proceed) begin
            case (info.kind)
                K_TAG: begin
                    r_idx                             <= info.tag_idx[IDX_W-1:0];
                    r_slot[info.tag_idx[IDX_W-1:0]]   <= '0;
                    r_neg                             <= 1'b0;
                end
                K_MINUS: begin
                    r_neg <= 1'b1;
                end
                K_DIGIT: begin
                    r_slot[r_idx] <= acc_value;
                end
                K_EOL: begin
                    r_idx <= '0;
                    r_neg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proceed && is_eol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && is_eol) begin
            r_out_data <= n_frame;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tdfp_checker.sv @@
// port-level checks of the tagged decimal frame parser, bound to the top level
`default_nettype none

`include "tagged_decimal_frame_parser_core_defines.svh"

module tdfp_checker
    import tdfp_pkg::*;
#(
    parameter int DATA_W = ((NUM_SLOTS_DEF * VALUE_WIDTH_DEF + 7) / 8) * 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [7:0]        s_axis_tdata,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [DATA_W-1:0] m_axis_tdata
);

    logic eol_in;

    assign eol_in = s_axis_tvalid && s_axis_tready
                 && (s_axis_tdata == CH_CR || s_axis_tdata == CH_LF);

    `TDFP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !m_axis_tvalid, "frame valid after reset")
    `TDFP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled frame changed")
    `TDFP_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without a waiting frame")
    `TDFP_ASSERT(a_eol_frame, eol_in && !m_axis_tvalid |=> ##1 m_axis_tvalid, "end of line gave no frame")

endmodule

bind tagged_decimal_frame_parser_core tdfp_checker #(
    .DATA_W (O_DATA_W)
) u_tdfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ verif/tdfp_frame_checker.sv @@
// frame checker for the tagged decimal frame parser: tracks slots and compares frames
`timescale 1ns / 100ps

module tdfp_frame_checker
    import tdfp_pkg::*;
#(
    parameter int DATA_W = ((NUM_SLOTS_DEF * VALUE_WIDTH_DEF + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rx_tvalid,
    input  wire logic              i_rx_tready,
    // rx_byte
    input  wire logic [7:0]        i_rx_tdata,
    input  wire logic              i_frame_tvalid,
    input  wire logic              i_frame_tready,
    // quat_w, quat_x, quat_y, quat_z, gyro_x, gyro_y, gyro_z, grav_x, grav_y, grav_z
    input  wire logic [DATA_W-1:0] i_frame_tdata,
    output int                     o_fail_count,
    output int                     o_frames_pending
);

    localparam int     NS      = NUM_SLOTS_DEF;
    localparam int     VW      = VALUE_WIDTH_DEF;
    localparam int     RADIX   = 10;
    localparam int     REPORTS = 10;
    localparam longint VAL_MAX = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    typedef logic signed [VW-1:0] t_value;

    string field_name [NS] = '{"quat_w", "quat_x", "quat_y", "quat_z", "gyro_x",
                               "gyro_y", "gyro_z", "grav_x", "grav_y", "grav_z"};

    t_value            slot_val [NS];
    int unsigned       cur_slot;
    bit                minus_active;
    logic [DATA_W-1:0] frames_due [$];
    int                mismatch_total = 0;

    // exact value*10 + signed digit, clamped to the signed value range
    function automatic t_value shift_in_digit(t_value v, int sd);
        longint acc;
        acc = longint'(v) * RADIX + sd;
        if (acc > VAL_MAX) begin
            return t_value'(VAL_MAX);
        end
        if (acc < VAL_MIN) begin
            return t_value'(VAL_MIN);
        end
        return t_value'(acc);
    endfunction

    function automatic void track_char(logic [7:0] c);
        logic [DATA_W-1:0] frame;
        int                d;
        frame = '0;
        if (c >= CH_FIRST_TAG && c < CH_FIRST_TAG + NS) begin
            cur_slot = c - CH_FIRST_TAG;
            slot_val[cur_slot] = '0;
            minus_active = 1'b0;
        end else if (c == CH_MINUS) begin
            minus_active = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            d = int'(c - CH_ZERO);
            slot_val[cur_slot] = shift_in_digit(slot_val[cur_slot], minus_active ? -d : d);
        end else if (c == CH_CR || c == CH_LF) begin
            cur_slot = 0;
            minus_active = 1'b0;
            for (int k = 0; k < NS; k++) begin
                frame[k*VW +: VW] = slot_val[k];
            end
            frames_due.push_back(frame);
        end
    endfunction

    function automatic void note_mismatch(string what, logic [VW-1:0] want,
                                          logic [VW-1:0] got);
        mismatch_total++;
        if (mismatch_total <= REPORTS) begin
            $display("[%0t] frame mismatch on %s: expected %0d, got %0d", $realtime, what,
                     $signed(want), $signed(got));
        end
    endfunction

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            foreach (slot_val[k]) begin
                slot_val[k] = '0;
            end
            cur_slot = 0;
            minus_active = 1'b0;
            frames_due.delete();
        end else begin
            if (i_frame_tvalid && i_frame_tready) begin
                if (frames_due.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORTS) begin
                        $display("[%0t] frame transfer with no frame expected", $realtime);
                    end
                end else begin
                    want = frames_due.pop_front();
                    for (int k = 0; k < NS; k++) begin
                        if (i_frame_tdata[k*VW +: VW] !== want[k*VW +: VW]) begin
                            note_mismatch(field_name[k], want[k*VW +: VW],
                                          i_frame_tdata[k*VW +: VW]);
                        end
                    end
                end
            end
            if (i_rx_tvalid && i_rx_tready) begin
                track_char(i_rx_tdata);
            end
        end
        o_fail_count     <= mismatch_total;
        o_frames_pending <= frames_due.size();
    end

endmodule

@@ verif/testbench.sv @@
// top of the tagged decimal frame parser testbench: clock, reset, byte stimulus, verdict
`timescale 1ns / 100ps

module testbench;
    import tdfp_pkg::*;

    localparam int O_DATA_W    = ((NUM_SLOTS_DEF * VALUE_WIDTH_DEF + 7) / 8) * 8;
    localparam int ITEMS       = 1350;
    localparam int CALM_TAIL   = 150;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 300000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;     // rx_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [O_DATA_W-1:0] m_axis_tdata;     // quat_w .. quat_z, gyro_x .. gyro_z, grav_x .. grav_z

    int fail_count;
    int frames_pending;
    int items_sent  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;
    bit hold_armed  = 1'b0;
    bit hold_done   = 1'b0;

    always #5 i_clk = ~i_clk;

    tagged_decimal_frame_parser_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tdfp_frame_checker #(
        .DATA_W (O_DATA_W)
    ) u_frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_tvalid      (s_axis_tvalid),
        .i_rx_tready      (s_axis_tready),
        .i_rx_tdata       (s_axis_tdata),
        .i_frame_tvalid   (m_axis_tvalid),
        .i_frame_tready   (m_axis_tready),
        .i_frame_tdata    (m_axis_tdata),
        .o_fail_count     (fail_count),
        .o_frames_pending (frames_pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit moves_state(logic [7:0] c);
        return (c >= CH_FIRST_TAG && c < CH_FIRST_TAG + NUM_SLOTS_DEF) || c == CH_MINUS ||
               (c >= CH_ZERO && c <= CH_NINE) || c == CH_CR || c == CH_LF;
    endfunction

    // one byte transfer, with a random idle burst ahead of it
    task automatic push_char(logic [7:0] c);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        if (moves_state(c)) begin
            items_sent++;
        end
    endtask

    task automatic push_digits(int n);
        repeat (n) push_char(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic push_random_frame();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 11) == 0) begin
                push_char(8'(CH_FIRST_TAG + NUM_SLOTS_DEF + $urandom_range(0, 15)));
            end else begin
                push_char(8'(CH_FIRST_TAG + $urandom_range(0, NUM_SLOTS_DEF - 1)));
            end
            if ($urandom_range(0, 5) == 0) begin
                push_char(CH_SPACE);
            end
            if ($urandom_range(0, 2) == 0) begin
                push_char(CH_MINUS);
            end
            if ($urandom_range(0, 9) == 0) begin
                push_digits($urandom_range(10, 12));
            end else begin
                push_digits($urandom_range(0, 4));
            end
            if ($urandom_range(0, 9) == 0) begin
                push_char(CH_MINUS);
                push_digits($urandom_range(1, 3));
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            push_char($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
    endtask

    // frame sink: random stalls, one long hold-off once the random part starts
    initial begin
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_armed && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // digits before any tag, repeated minus, ignored bytes, space
        push_char(8'(CH_ZERO + 7));
        push_char(CH_MINUS);
        push_char(CH_MINUS);
        push_char(8'(CH_ZERO + 3));
        push_char(8'hFF);
        push_char(8'h00);
        push_char(8'h80);
        push_char(8'(CH_FIRST_TAG + NUM_SLOTS_DEF));
        push_char(CH_SPACE);
        push_char(CH_LF);
        // minus between digits
        push_char(8'(CH_FIRST_TAG + 1));
        push_char(8'(CH_ZERO + 4));
        push_char(CH_MINUS);
        push_char(8'(CH_ZERO + 2));
        push_char(CH_CR);
        // negative saturation on the last slot
        push_char(8'(CH_FIRST_TAG + NUM_SLOTS_DEF - 1));
        push_char(CH_MINUS);
        repeat (10) push_char(CH_NINE);
        push_char(CH_CR);

        hold_armed = 1'b1;
        while (items_sent < ITEMS) begin
            calm = (items_sent > ITEMS - CALM_TAIL);
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
            end else begin
                push_random_frame();
            end
        end
        push_char(CH_LF);
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (frames_pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && frames_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tdfp_pkg.sv
hw/rtl/tdfp_char_decode.sv
hw/rtl/tdfp_digit_acc.sv
hw/rtl/tagged_decimal_frame_parser_core.sv
hw/rtl/tdfp_checker.sv
verif/tdfp_frame_checker.sv
verif/testbench.sv
